@@ sv/nearest_neighbor_route_builder_macros.svh @@
// ----------------------------------------------------------------------------
// nearest_neighbor_route_builder_macros.svh
// Assertion helpers shared by the route builder RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_ROUTE_BUILDER_MACROS_SVH
`define NEAREST_NEIGHBOR_ROUTE_BUILDER_MACROS_SVH

// Plain property, sampled on clk, off during reset
`define NNRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define NNRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/nnrb_pkg.sv @@
// ----------------------------------------------------------------------------
// nnrb_pkg
// Shared types and constants of the nearest neighbor route builder.
// ----------------------------------------------------------------------------
package nnrb_pkg;

	// default sizing
	localparam int MAX_NODES_DEF   = 64;
	localparam int COORD_BITS_DEF  = 16;
	localparam int DEMAND_BITS_DEF = 16;

	// fixed field widths
	localparam int ID_W      = 7;
	localparam int LEG_W     = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd2;

	// input opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_START = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETCUR,
		ST_USECUR,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// control tag that travels with each distance evaluation
	typedef struct packed {
		logic vld;
		logic last;
		logic skip;
	} tag_t;

endpackage

@@ sv/nnrb_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// nnrb_sqrt_cell
// One digit step of a restoring square root; registered toward the next cell.
// ----------------------------------------------------------------------------
module nnrb_sqrt_cell import nnrb_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int IW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tag_t              tag_i,
	input  logic [IW-1:0]     idx_i,
	input  logic [2*CB+1:0]   num_i,
	input  logic [CB+3:0]     rem_i,
	input  logic [CB:0]       root_i,
	output tag_t              tag_o,
	output logic [IW-1:0]     idx_o,
	output logic [2*CB+1:0]   num_o,
	output logic [CB+3:0]     rem_o,
	output logic [CB:0]       root_o
);

	localparam int NW = 2*CB + 2;
	localparam int RW = CB + 4;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          fits;

	// bring down the next two bits and try (root << 2) | 1
	always_comb begin
		rem_sh = {rem_i[RW-3:0], num_i[NW-1:NW-2]};
		trial  = {1'b0, root_i, 2'b01};
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_o <= '0;
		end else begin
			tag_o <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		idx_o  <= idx_i;
		num_o  <= {num_i[NW-3:0], 2'b00};
		rem_o  <= fits ? (rem_sh - trial) : rem_sh;
		root_o <= {root_i[CB-1:0], fits};
	end

endmodule

@@ sv/nnrb_dist_pipe.sv @@
// ----------------------------------------------------------------------------
// nnrb_dist_pipe
// Rounded Euclidean distance: difference, square, sum, a chain of root cells.
// ----------------------------------------------------------------------------
module nnrb_dist_pipe import nnrb_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int IW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tag_t            tag_i,
	input  logic [IW-1:0]   idx_i,
	input  logic [CB-1:0]   px,
	input  logic [CB-1:0]   py,
	input  logic [CB-1:0]   cx,
	input  logic [CB-1:0]   cy,
	output tag_t            tag_o,
	output logic [IW-1:0]   idx_o,
	output logic [CB+1:0]   dist_o
);

	localparam int NW = 2*CB + 2;
	localparam int RW = CB + 4;
	localparam int QW = CB + 1;
	localparam int NC = CB + 1;

	tag_t            tag_s1, tag_s2, tag_s3, tag_s4;
	logic [IW-1:0]   idx_s1, idx_s2, idx_s3, idx_s4;
	logic [CB-1:0]   dx_s1, dy_s1;
	logic [2*CB-1:0] sx_s2, sy_s2;
	logic [NW-1:0]   sum_s3;
	logic [CB+1:0]   dist_s4;

	tag_t            c_tag  [NC+1];
	logic [IW-1:0]   c_idx  [NC+1];
	logic [NW-1:0]   c_num  [NC+1];
	logic [RW-1:0]   c_rem  [NC+1];
	logic [QW-1:0]   c_root [NC+1];

	// control tags of the front stages and the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_i;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= c_tag[NC];
		end
	end

	// absolute differences, squares, sum
	always_ff @(posedge clk) begin
		idx_s1 <= idx_i;
		dx_s1  <= (px > cx) ? (px - cx) : (cx - px);
		dy_s1  <= (py > cy) ? (py - cy) : (cy - py);
		idx_s2 <= idx_s1;
		sx_s2  <= dx_s1 * dx_s1;
		sy_s2  <= dy_s1 * dy_s1;
		idx_s3 <= idx_s2;
		sum_s3 <= NW'(sx_s2) + NW'(sy_s2);
	end

	assign c_tag[0]  = tag_s3;
	assign c_idx[0]  = idx_s3;
	assign c_num[0]  = sum_s3;
	assign c_rem[0]  = '0;
	assign c_root[0] = '0;

	// one root digit per cell
	for (genvar k = 0; k < NC; k++) begin : g_cell
		nnrb_sqrt_cell #(.CB(CB), .IW(IW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tag_i  (c_tag[k]),
			.idx_i  (c_idx[k]),
			.num_i  (c_num[k]),
			.rem_i  (c_rem[k]),
			.root_i (c_root[k]),
			.tag_o  (c_tag[k+1]),
			.idx_o  (c_idx[k+1]),
			.num_o  (c_num[k+1]),
			.rem_o  (c_rem[k+1]),
			.root_o (c_root[k+1])
		);
	end

	// round half up: remainder above root means the next integer
	always_ff @(posedge clk) begin
		idx_s4  <= c_idx[NC];
		dist_s4 <= (CB+2)'(c_root[NC]) + (CB+2)'(c_rem[NC] > RW'(c_root[NC]));
	end

	assign tag_o  = tag_s4;
	assign idx_o  = idx_s4;
	assign dist_o = dist_s4;

endmodule

@@ sv/nearest_neighbor_route_builder.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_route_builder
// Greedy nearest neighbor tour over stored nodes with capacity route breaks.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall): op 0 loads x, y and demand at
//  node_index; op 1 starts a tour over node_count nodes from the depot or
//  from first_customer when that names a valid non-depot node.
//  Output channel (out_valid/out_stall): one transaction per customer with
//  customer_id, leg_distance, route_break and last on the final customer.
//  Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
//  node_count, depot_index or vehicle_capacity; write while idle.
//  Each customer costs one scan of n nodes through the distance pipe plus
//  its latency. The pipe takes one node per cycle; the root chain sets the
//  latency. in_stall stays high from start until the last customer is
//  handed to the output register. A stalled output holds its transaction;
//  the walk waits for it only when the next customer is ready to go out.
//  Reset clears visited marks and control; the node store is not cleared
//  and must be loaded before a start.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_route_builder_macros.svh"

module nearest_neighbor_route_builder import nnrb_pkg::*; #(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int DEMAND_BITS = DEMAND_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [5:0]           node_index,
	input  logic [15:0]          node_x,
	input  logic [15:0]          node_y,
	input  logic [15:0]          node_demand,
	input  logic [6:0]           first_customer,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ID_W-1:0]      customer_id,
	output logic [LEG_W-1:0]     leg_distance,
	output logic                 route_break,
	output logic                 last,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int DB = DEMAND_BITS;
	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int LW = ((DB > 16) ? DB : 16) + 1;
	localparam int DW = CB + 2;

	state_t state_q, state_d;

	// configuration registers
	logic [6:0]  node_count_q;
	logic [6:0]  depot_index_q;
	logic [15:0] capacity_q;

	// node store
	logic [CB-1:0] x_mem [MAX_NODES];
	logic [CB-1:0] y_mem [MAX_NODES];
	logic [DB-1:0] d_mem [MAX_NODES];
	logic [CB-1:0] rd_x_q, rd_y_q;
	logic [DB-1:0] rd_d_q;
	logic [IW-1:0] rd_addr;

	// walk state
	logic [MAX_NODES-1:0] visited_q;
	logic [CW-1:0]        n_q, cnt_q, cnt_nxt;
	logic [IW-1:0]        fc_q, tgt_q, scan_q, best_idx_q, n_last;
	logic                 fc_pend_q, emit_q, found_q;
	logic [DW-1:0]        sdist_q, best_d_q;
	logic [LW-1:0]        load_q, load_sum;
	logic [CB-1:0]        cur_x_q, cur_y_q;

	// scan issue stage and distance pipe
	tag_t          tag_s1, po_tag;
	logic [IW-1:0] idx_s1, po_idx;
	logic [DW-1:0] po_dist;

	// output register
	logic             out_v_q;
	logic [ID_W-1:0]  cust_q;
	logic [LEG_W-1:0] dist_q;
	logic             brk_q, last_q;

	// start decode
	logic [XW-1:0] n_x, dep_x, fc_x;
	logic          fc_ok, acc, acc_load, acc_start;
	logic          out_free, proceed, take, brk, is_last;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign acc_load  = acc && (op == OP_LOAD);
	assign acc_start = acc && (op == OP_START);

	// clamp node count and depot, check forced first customer
	always_comb begin
		n_x   = (int'(node_count_q) > MAX_NODES) ? XW'(MAX_NODES) : XW'(node_count_q);
		dep_x = (depot_index_q == '0) ? XW'(1) :
		        ((XW'(depot_index_q) > n_x) ? n_x : XW'(depot_index_q));
		fc_x  = XW'(first_customer);
		fc_ok = (fc_x != '0) && (fc_x <= n_x) && (fc_x != dep_x);
	end

	// emission arithmetic
	always_comb begin
		out_free = !out_v_q || !out_stall;
		proceed  = !emit_q || out_free;
		cnt_nxt  = cnt_q + CW'(emit_q);
		n_last   = IW'(n_q - CW'(1));
		load_sum = load_q + LW'(rd_d_q);
		brk      = (load_sum > LW'(capacity_q));
		is_last  = (cnt_nxt == n_q - CW'(1));
		take     = po_tag.vld && !po_tag.skip && (!found_q || (po_dist < best_d_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_start && (n_x >= XW'(2)))
					state_d = ST_SETCUR;
			end
			ST_SETCUR: state_d = ST_USECUR;
			ST_USECUR: begin
				if (proceed) begin
					if (fc_pend_q)
						state_d = ST_SETCUR;
					else if (cnt_nxt == n_q - CW'(1))
						state_d = ST_IDLE;
					else
						state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == n_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (po_tag.vld && po_tag.last)
					state_d = ST_SETCUR;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// store read address
	always_comb begin
		case (state_q)
			ST_SCAN: rd_addr = scan_q;
			default: rd_addr = tgt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= 7'd2;
			depot_index_q <= 7'd1;
			capacity_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NODE_COUNT: node_count_q  <= cfg_data[6:0];
				CFG_DEPOT:      depot_index_q <= cfg_data[6:0];
				CFG_CAPACITY:   capacity_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// node store write and registered read
	always_ff @(posedge clk) begin
		if (acc_load && (int'(node_index) < MAX_NODES)) begin
			x_mem[IW'(node_index)] <= CB'(node_x);
			y_mem[IW'(node_index)] <= CB'(node_y);
			d_mem[IW'(node_index)] <= DB'(node_demand);
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
		rd_d_q <= d_mem[rd_addr];
	end

	// scan issue: one node per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld  <= (state_q == ST_SCAN);
			tag_s1.last <= (scan_q == n_last);
			tag_s1.skip <= visited_q[scan_q];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
	end

	nnrb_dist_pipe #(.CB(CB), .IW(IW)) u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_i  (tag_s1),
		.idx_i  (idx_s1),
		.px     (rd_x_q),
		.py     (rd_y_q),
		.cx     (cur_x_q),
		.cy     (cur_y_q),
		.tag_o  (po_tag),
		.idx_o  (po_idx),
		.dist_o (po_dist)
	);

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q  <= '0;
			n_q        <= CW'(2);
			cnt_q      <= '0;
			load_q     <= '0;
			fc_q       <= '0;
			fc_pend_q  <= 1'b0;
			tgt_q      <= '0;
			emit_q     <= 1'b0;
			sdist_q    <= '0;
			scan_q     <= '0;
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_d_q   <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_start) begin
						visited_q                     <= '0;
						visited_q[IW'(dep_x - XW'(1))] <= 1'b1;
						n_q       <= CW'(n_x);
						cnt_q     <= '0;
						load_q    <= '0;
						tgt_q     <= IW'(dep_x - XW'(1));
						emit_q    <= 1'b0;
						sdist_q   <= '0;
						fc_q      <= IW'(fc_x - XW'(1));
						fc_pend_q <= fc_ok;
					end
				end
				ST_USECUR: begin
					if (proceed) begin
						cur_x_q <= rd_x_q;
						cur_y_q <= rd_y_q;
						scan_q  <= '0;
						found_q <= 1'b0;
						if (emit_q) begin
							visited_q[tgt_q] <= 1'b1;
							cnt_q            <= cnt_nxt;
							load_q           <= brk ? LW'(rd_d_q) : load_sum;
						end
						if (fc_pend_q) begin
							tgt_q     <= fc_q;
							emit_q    <= 1'b1;
							sdist_q   <= '0;
							fc_pend_q <= 1'b0;
						end
					end
				end
				ST_SCAN, ST_DRAIN: begin
					if (state_q == ST_SCAN)
						scan_q <= scan_q + IW'(1);
					if (take) begin
						found_q    <= 1'b1;
						best_idx_q <= po_idx;
						best_d_q   <= po_dist;
					end
					if (po_tag.vld && po_tag.last) begin
						tgt_q   <= take ? po_idx : best_idx_q;
						sdist_q <= take ? po_dist : best_d_q;
						emit_q  <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((state_q == ST_USECUR) && emit_q && out_free) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_USECUR) && emit_q && out_free) begin
			cust_q <= ID_W'(tgt_q) + ID_W'(1);
			dist_q <= LEG_W'(sdist_q);
			brk_q  <= brk;
			last_q <= is_last;
		end
	end

	assign out_valid    = out_v_q;
	assign customer_id  = cust_q;
	assign leg_distance = dist_q;
	assign route_break  = brk_q;
	assign last         = last_q;

	// checks
	`NNRB_ASSERT_IMP(a_cnt_bound, state_q != ST_IDLE, cnt_q < n_q, "count ran past n-1")
	`NNRB_ASSERT_IMP(a_pipe_scan, po_tag.vld, (state_q == ST_SCAN) || (state_q == ST_DRAIN),
		"distance result outside a scan")
	`NNRB_ASSERT_IMP(a_pick_fresh, (state_q == ST_SETCUR) && emit_q, !visited_q[tgt_q],
		"picked node already visited")

endmodule
